@@ rtl/core/sec_pkg.sv @@
// Shared types and constants for the single elevator controller.
`default_nettype none
package sec_pkg;
    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_ARRIVE  = 4'd1,
        EV_EXIT    = 4'd2,
        EV_BOARD   = 4'd3,
        EV_CLOSING = 4'd4,
        EV_DEPART  = 4'd5,
        EV_LOBBY   = 4'd6,
        EV_OPEN    = 4'd7,
        EV_ACCEPT  = 4'd8,
        EV_REJECT  = 4'd9
    } t_event;
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;
    localparam int unsigned CFG_OPEN     = 0;
    localparam int unsigned CFG_TRANSFER = 1;
    localparam int unsigned CFG_CLOSE    = 2;
    localparam int unsigned CFG_MOVE     = 3;
    localparam int unsigned CFG_IDLE     = 4;
    localparam int unsigned CFG_LOBBY    = 5;
    localparam int unsigned NUM_CFG      = 6;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned TICK_BITS    = 16;
    localparam int unsigned FLOOR_BITS   = 3;
    localparam int unsigned FILL_BITS    = 5;
    localparam logic [TICK_BITS-1:0] IDLE_SAT = 16'hFFFF;
endpackage
`default_nettype wire

@@ rtl/core/sec_stream_if.sv @@
// Valid/ready channel carrying a packed payload.
`default_nettype none
interface sec_stream_if #(parameter int unsigned WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/single_elevator_controller_core.sv @@
// Top level of the single elevator controller: sequencer, car list and wait stacks.
// An arrival or a plain tick passes through decode and emit; a door expiry may first scan
// the car list and shift it, and an idle decision first walks all floors.
// One item at a time: the car-list scan and the floor scan keep the sequencer busy, and
// the result register then waits for its taker before a new item is accepted.
// Reset (synchronous, active low) restores config defaults and car, door, timer and fill state; the car is at floor 1.
`default_nettype none
module single_elevator_controller_core
    import sec_pkg::*;
#(
    parameter int unsigned NUM_FLOORS   = 8,
    parameter int unsigned CAR_CAPACITY = 16,
    parameter int unsigned WAIT_DEPTH   = 16,
    parameter int unsigned ID_BITS      = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [TICK_BITS-1:0]    i_cfg_data,
    sec_stream_if.sink                   in_if,
    sec_stream_if.source                 out_if
);
    localparam int unsigned CAR_AW  = (CAR_CAPACITY > 1) ? $clog2(CAR_CAPACITY) : 1;
    localparam int unsigned CAR_CW  = $clog2(CAR_CAPACITY + 1);
    localparam int unsigned WD_AW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int unsigned WD_CW   = $clog2(WAIT_DEPTH + 1);
    localparam int unsigned FL_AW   = $clog2(NUM_FLOORS);
    localparam int unsigned W_DEPTH = NUM_FLOORS * (1 << WD_AW);
    localparam int unsigned W_AW    = FL_AW + WD_AW;
    localparam int unsigned ENT_W   = ID_BITS + FLOOR_BITS;
    localparam logic [FLOOR_BITS-1:0] TOP_FLOOR = FLOOR_BITS'(NUM_FLOORS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR,
        S_BOARD_RD, S_BOARD_WR, S_FLOOR, S_EMIT
    } t_state;

    t_state r_state;
    logic [TICK_BITS-1:0] r_open, r_xfer, r_close, r_move, r_idle_lim;
    logic [FLOOR_BITS-1:0] r_lobby;
    logic [FLOOR_BITS-1:0] r_floor;
    logic [1:0] r_heading;
    logic r_door, r_closing;
    logic [TICK_BITS-1:0] r_door_cnt, r_move_cnt, r_idle_cnt;
    logic [CAR_CW-1:0] r_car_fill;
    logic [WD_CW-1:0] r_wait_fill [NUM_FLOORS];
    logic [CAR_CW-1:0] r_idx;
    logic [FL_AW:0] r_fidx;
    logic [FLOOR_BITS-1:0] r_best;
    logic [FLOOR_BITS:0] r_best_d;
    logic r_demand;
    logic r_action;
    logic [ID_BITS-1:0] r_id;
    logic [FLOOR_BITS-1:0] r_org, r_tgt;
    logic [3:0] r_code;
    logic [ID_BITS-1:0] r_rider;
    logic r_out_valid;

    // car list RAM
    logic car_we;
    logic [CAR_AW-1:0] car_waddr, car_raddr;
    logic [ENT_W-1:0] car_wdata, car_rdata;
    sec_ram #(.WIDTH(ENT_W), .DEPTH(1 << CAR_AW)) u_car (
        .i_clk(i_clk), .i_we(car_we), .i_waddr(car_waddr), .i_wdata(car_wdata),
        .i_raddr(car_raddr), .o_rdata(car_rdata)
    );
    // wait stacks RAM
    logic w_we;
    logic [W_AW-1:0] w_waddr, w_raddr;
    logic [ENT_W-1:0] w_wdata, w_rdata;
    sec_ram #(.WIDTH(ENT_W), .DEPTH(W_DEPTH)) u_wait (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    function automatic logic [TICK_BITS-1:0] at_least_one(input logic [TICK_BITS-1:0] v);
        return (v == '0) ? TICK_BITS'(1) : v;
    endfunction

    logic [FLOOR_BITS-1:0] lobby_eff;
    assign lobby_eff = (32'(r_lobby) < NUM_FLOORS) ? r_lobby : TOP_FLOOR;

    logic [FL_AW-1:0] floor_ix, org_ix;
    assign floor_ix = r_floor[FL_AW-1:0];
    assign org_ix   = r_org[FL_AW-1:0];
    logic [WD_CW-1:0] here_fill, org_fill;
    assign here_fill = r_wait_fill[floor_ix];
    assign org_fill  = r_wait_fill[org_ix];
    logic arr_ok;
    assign arr_ok = (32'(r_org) < NUM_FLOORS) && (32'(r_tgt) < NUM_FLOORS)
                    && (r_org != r_tgt) && (32'(org_fill) < WAIT_DEPTH);

    // compare unit: distance of scanned floor
    logic [FL_AW-1:0] scan_f;
    logic [FLOOR_BITS-1:0] scan_f3;
    logic [FLOOR_BITS:0] scan_d;
    assign scan_f  = r_fidx[FL_AW-1:0];
    assign scan_f3 = FLOOR_BITS'(scan_f);
    assign scan_d  = (scan_f3 > r_floor) ? {1'b0, scan_f3 - r_floor}
                                         : {1'b0, r_floor - scan_f3};

    logic [CAR_AW-1:0] idx_a;
    assign idx_a = r_idx[CAR_AW-1:0];
    logic [WD_AW-1:0] top_slot;
    assign top_slot = WD_AW'(here_fill - WD_CW'(1));

    always_comb begin
        car_we = 1'b0; car_waddr = idx_a; car_wdata = car_rdata; car_raddr = idx_a;
        w_we = 1'b0; w_waddr = {org_ix, WD_AW'(org_fill)}; w_wdata = {r_id, r_tgt};
        w_raddr = {floor_ix, top_slot};
        case (r_state)
            S_DECODE: w_we = r_action && arr_ok;
            // fetch the entry below the cursor so it is ready in the check cycle
            S_SCAN: car_raddr = CAR_AW'(r_idx - CAR_CW'(1));
            S_SHIFT_RD: car_raddr = CAR_AW'(r_idx + CAR_CW'(1));
            S_SHIFT_WR: car_we = 1'b1;
            S_BOARD_WR: begin
                car_we = 1'b1; car_waddr = CAR_AW'(r_car_fill); car_wdata = w_rdata;
            end
            default: ;
        endcase
    end

    assign in_if.ready = (r_state == S_IDLE) && !r_out_valid;
    assign out_if.valid = r_out_valid;
    assign out_if.data = {r_code, r_rider, r_floor, r_heading, r_door, FILL_BITS'(r_car_fill)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open <= 16'd10; r_xfer <= 16'd10; r_close <= 16'd10;
            r_move <= 16'd20; r_idle_lim <= 16'd300; r_lobby <= 3'd1;
            r_floor <= 3'd1; r_heading <= DIR_IDLE; r_door <= 1'b0; r_closing <= 1'b0;
            r_door_cnt <= '0; r_move_cnt <= '0; r_idle_cnt <= '0; r_car_fill <= '0;
            for (int f = 0; f < NUM_FLOORS; f++) r_wait_fill[f] <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (32'(i_cfg_idx))
                    CFG_OPEN:     r_open <= i_cfg_data;
                    CFG_TRANSFER: r_xfer <= i_cfg_data;
                    CFG_CLOSE:    r_close <= i_cfg_data;
                    CFG_MOVE:     r_move <= i_cfg_data;
                    CFG_IDLE:     r_idle_lim <= i_cfg_data;
                    CFG_LOBBY:    r_lobby <= i_cfg_data[FLOOR_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (in_if.valid && in_if.ready) begin
                    {r_action, r_id, r_org, r_tgt} <= in_if.data;
                    r_state <= S_DECODE;
                end
                S_DECODE: begin
                    r_code <= EV_NONE; r_rider <= '0; r_state <= S_EMIT;
                    if (r_action) begin
                        r_rider <= r_id;
                        if (arr_ok) begin
                            r_wait_fill[org_ix] <= org_fill + WD_CW'(1);
                            r_code <= EV_ACCEPT;
                        end else r_code <= EV_REJECT;
                    end else if (r_move_cnt != '0) begin
                        r_move_cnt <= r_move_cnt - 1'b1;
                        if (r_move_cnt == TICK_BITS'(1)) begin
                            if (r_heading == DIR_UP && r_floor != TOP_FLOOR)
                                r_floor <= r_floor + 1'b1;
                            else if (r_heading == DIR_DOWN && r_floor != '0)
                                r_floor <= r_floor - 1'b1;
                            r_door <= 1'b1; r_closing <= 1'b0;
                            r_door_cnt <= at_least_one(r_open); r_idle_cnt <= '0;
                            r_code <= EV_ARRIVE;
                        end
                    end else if (r_door) begin
                        if (r_door_cnt > TICK_BITS'(1)) r_door_cnt <= r_door_cnt - 1'b1;
                        else if (r_closing) begin
                            r_door <= 1'b0; r_closing <= 1'b0; r_door_cnt <= '0;
                            if (r_car_fill != '0) begin
                                if (r_heading == DIR_UP && r_floor >= TOP_FLOOR)
                                    r_heading <= DIR_DOWN;
                                else if (r_heading == DIR_DOWN && r_floor == '0)
                                    r_heading <= DIR_UP;
                                r_move_cnt <= at_least_one(r_move);
                                r_code <= EV_DEPART;
                            end else r_heading <= DIR_IDLE;
                        end else begin
                            r_idx <= r_car_fill; r_state <= S_SCAN;
                        end
                    end else begin
                        if (r_idle_cnt != IDLE_SAT) r_idle_cnt <= r_idle_cnt + 1'b1;
                        r_fidx <= '0; r_demand <= 1'b0; r_best <= '0;
                        r_best_d <= '1; r_state <= S_FLOOR;
                    end
                end
                // walk the car list from the top: fetch in scan, compare in the check state
                S_SCAN: begin
                    if (r_idx == '0) begin
                        if (here_fill != '0 && 32'(r_car_fill) < CAR_CAPACITY)
                            r_state <= S_BOARD_RD;
                        else begin
                            r_closing <= 1'b1; r_door_cnt <= at_least_one(r_close);
                            r_code <= EV_CLOSING; r_state <= S_EMIT;
                        end
                    end else begin
                        r_idx <= r_idx - 1'b1; r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (car_rdata[FLOOR_BITS-1:0] == r_floor) begin
                        r_rider <= car_rdata[ENT_W-1:FLOOR_BITS];
                        r_code <= EV_EXIT; r_door_cnt <= at_least_one(r_xfer);
                        r_state <= S_SHIFT_RD;
                    end else r_state <= S_SCAN;
                end
                // close the gap: move entry idx+1 down to idx
                S_SHIFT_RD: begin
                    if (32'(r_idx) + 1 >= 32'(r_car_fill)) begin
                        r_car_fill <= r_car_fill - 1'b1; r_state <= S_EMIT;
                    end else r_state <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    r_idx <= r_idx + 1'b1; r_state <= S_SHIFT_RD;
                end
                S_BOARD_RD: r_state <= S_BOARD_WR;
                S_BOARD_WR: begin
                    r_wait_fill[floor_ix] <= here_fill - WD_CW'(1);
                    r_car_fill <= r_car_fill + 1'b1;
                    r_rider <= w_rdata[ENT_W-1:FLOOR_BITS];
                    r_heading <= (w_rdata[FLOOR_BITS-1:0] > r_floor) ? DIR_UP : DIR_DOWN;
                    r_door_cnt <= at_least_one(r_xfer);
                    r_code <= EV_BOARD; r_state <= S_EMIT;
                end
                // nearest demand floor, one floor per cycle
                S_FLOOR: begin
                    if (32'(r_fidx) < NUM_FLOORS) begin
                        if (r_wait_fill[scan_f] != '0) begin
                            r_demand <= 1'b1;
                            if (scan_d < r_best_d) begin
                                r_best_d <= scan_d; r_best <= scan_f3;
                            end
                        end
                        r_fidx <= r_fidx + 1'b1;
                    end else begin
                        r_state <= S_EMIT;
                        if (!r_demand) begin
                            if (r_idle_cnt > r_idle_lim && r_floor != lobby_eff) begin
                                r_heading <= (r_floor < lobby_eff) ? DIR_UP : DIR_DOWN;
                                r_move_cnt <= at_least_one(r_move);
                                r_code <= EV_LOBBY;
                            end
                        end else if (r_best == r_floor) begin
                            r_door <= 1'b1; r_closing <= 1'b0;
                            r_door_cnt <= at_least_one(r_open); r_idle_cnt <= '0;
                            r_code <= EV_OPEN;
                        end else begin
                            r_heading <= (r_best > r_floor) ? DIR_UP : DIR_DOWN;
                            r_move_cnt <= at_least_one(r_move);
                            r_code <= EV_DEPART;
                        end
                    end
                end
                S_EMIT: begin
                    r_out_valid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/sec_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sec_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/sec_checker.sv @@
// Port-level checks for the elevator controller, bound to the top level.
`default_nettype none
module sec_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [30:0] out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken during work");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data[30:27] <= 4'd9)
        else $error("bad event code");
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data[7:6] != 2'd3)
        else $error("bad direction");
endmodule
bind single_elevator_controller_core sec_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire
